@@ src/crt_pkg.sv @@
`default_nettype none
package crt_pkg;

	localparam int ID_W  = 29;
	localparam int IDX_W = 7;

	typedef enum logic [2:0] {
		OP_ROUTE_RX   = 3'd0,
		OP_FIND_TX    = 3'd1,
		OP_MAP        = 3'd2,
		OP_REGISTER   = 3'd3,
		OP_UNREGISTER = 3'd4,
		OP_CLEAR_ALL  = 3'd5
	} op_e;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_INVALID    = 2'd1,
		ST_NO_SPACE   = 2'd2,
		ST_NOT_MAPPED = 2'd3
	} status_e;

	typedef enum logic [1:0] {
		KIND_NONE    = 2'd0,
		KIND_CHANNEL = 2'd1,
		KIND_SLOT    = 2'd2
	} kind_e;

	typedef struct packed {
		logic [2:0]      operation;
		logic [1:0]      controller;
		logic [ID_W-1:0] frame_id;
		logic [3:0]      channel;
		logic [ID_W-1:0] transmit_id;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [1:0] target_kind;
		logic [4:0] target_index;
		logic [1:0] target_controller;
	} rsp_t;

	// lookup travelling down the row of cells
	typedef struct packed {
		logic             valid;
		op_e              op;
		logic [ID_W-1:0]  id;
		logic             ctrl_ok;
		logic             found;
		kind_e            kind;
		logic [IDX_W-1:0] idx;
		logic [1:0]       tctrl;
		logic             free_found;
		logic [IDX_W-1:0] free_idx;
	} token_t;

	// table update broadcast to all cells
	typedef struct packed {
		logic             clear_all;
		logic             chan_wr;
		logic             slot_wr;
		logic             slot_free;
		logic [IDX_W-1:0] idx;
		logic [ID_W-1:0]  id;
		logic [ID_W-1:0]  tx_id;
		logic [1:0]       ctrl;
	} upd_t;

endpackage
`default_nettype wire

@@ src/can_id_routing_table_unit.sv @@
// CAN identifier routing table: CHANNEL_COUNT transport channel cells followed by
// HANDLER_COUNT handler slot cells form one row, and every request walks down that row
// one cell per clock, each cell checking its own entry and passing the first match on.
// One request is handled at a time, and table updates land at the edge that ends the walk.
// The finished response then passes through a one-entry buffer before it moves to the output
// register. A new request is taken only while no request walks the row and that buffer is
// empty, so a response held in the output register stalls the request side only once the
// following request has finished its walk. controllers_in_use is written through cfg_we/
// cfg_wdata; the user must write it only while no request is in flight, as the block itself
// does not enforce this. It resets to 1.
`default_nettype none
module can_id_routing_table_unit #(
	parameter int CHANNEL_COUNT  = 16,
	parameter int HANDLER_COUNT  = 32,
	parameter int CONTROLLER_MAX = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [2:0]    cfg_wdata,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire crt_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output crt_pkg::rsp_t      rsp
);

	localparam int CELLS = CHANNEL_COUNT + HANDLER_COUNT;

	logic [2:0]                 ctrl_use_q;
	logic                       scan_q;
	logic                       pend_valid_q;
	crt_pkg::rsp_t              pend_q;
	crt_pkg::rsp_t              rsp_q;
	logic                       rsp_valid_q;
	logic [3:0]                 channel_q;
	logic [crt_pkg::ID_W-1:0]   tx_id_q;
	logic [1:0]                 ctrl_q;
	logic                       accept;
	logic                       ctrl_ok;
	logic                       map_ok;
	crt_pkg::token_t            tok_head;
	crt_pkg::token_t            tok [0:CELLS];
	crt_pkg::token_t            tok_end;
	crt_pkg::rsp_t              res;
	crt_pkg::upd_t              upd;

	assign req_stall = scan_q || pend_valid_q;
	assign accept    = req_valid && !req_stall;
	assign ctrl_ok   = ({1'b0, req.controller} < ctrl_use_q)
		&& (32'(req.controller) < CONTROLLER_MAX);

	always_comb begin
		tok_head          = '0;
		tok_head.valid    = accept;
		tok_head.op       = crt_pkg::op_e'(req.operation);
		tok_head.id       = req.frame_id;
		tok_head.ctrl_ok  = ctrl_ok;
		tok_head.kind     = crt_pkg::KIND_NONE;
	end

	assign tok[0] = tok_head;

	for (genvar i = 0; i < CHANNEL_COUNT; i++) begin : g_chan
		crt_chan_cell #(.IDX(i)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok[i]),
			.upd     (upd),
			.tok_out (tok[i+1])
		);
	end

	for (genvar j = 0; j < HANDLER_COUNT; j++) begin : g_slot
		crt_slot_cell #(.IDX(j)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok[CHANNEL_COUNT+j]),
			.upd     (upd),
			.tok_out (tok[CHANNEL_COUNT+j+1])
		);
	end

	assign tok_end = tok[CELLS];
	assign map_ok  = (32'(channel_q) < CHANNEL_COUNT) && tok_end.ctrl_ok;

	always_comb begin
		res           = '0;
		res.status    = crt_pkg::ST_INVALID;
		upd           = '0;
		upd.id        = tok_end.id;
		upd.tx_id     = tx_id_q;
		upd.ctrl      = ctrl_q;
		upd.idx       = tok_end.idx;
		case (tok_end.op)
			crt_pkg::OP_ROUTE_RX: begin
				if (tok_end.ctrl_ok) begin
					res.status       = crt_pkg::ST_OK;
					res.target_kind  = tok_end.kind;
					res.target_index = tok_end.idx[4:0];
				end
			end
			crt_pkg::OP_FIND_TX: begin
				if (tok_end.found) begin
					res.status            = crt_pkg::ST_OK;
					res.target_kind       = crt_pkg::KIND_CHANNEL;
					res.target_index      = tok_end.idx[4:0];
					res.target_controller = tok_end.tctrl;
				end else begin
					res.status = crt_pkg::ST_NOT_MAPPED;
				end
			end
			crt_pkg::OP_MAP: begin
				if (map_ok) begin
					res.status       = crt_pkg::ST_OK;
					res.target_kind  = crt_pkg::KIND_CHANNEL;
					res.target_index = 5'(channel_q);
					upd.chan_wr      = tok_end.valid;
					upd.idx          = crt_pkg::IDX_W'(channel_q);
				end
			end
			crt_pkg::OP_REGISTER: begin
				if (tok_end.found) begin
					res.status       = crt_pkg::ST_OK;
					res.target_kind  = crt_pkg::KIND_SLOT;
					res.target_index = tok_end.idx[4:0];
				end else if (tok_end.free_found) begin
					res.status       = crt_pkg::ST_OK;
					res.target_kind  = crt_pkg::KIND_SLOT;
					res.target_index = tok_end.free_idx[4:0];
					upd.slot_wr      = tok_end.valid;
					upd.idx          = tok_end.free_idx;
				end else begin
					res.status = crt_pkg::ST_NO_SPACE;
				end
			end
			crt_pkg::OP_UNREGISTER: begin
				if (tok_end.found) begin
					res.status       = crt_pkg::ST_OK;
					res.target_kind  = crt_pkg::KIND_SLOT;
					res.target_index = tok_end.idx[4:0];
					upd.slot_free    = tok_end.valid;
				end
			end
			crt_pkg::OP_CLEAR_ALL: begin
				res.status    = crt_pkg::ST_OK;
				upd.clear_all = tok_end.valid;
			end
			default: begin
				res.status = crt_pkg::ST_INVALID;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_use_q <= 3'd1;
		end else if (cfg_we) begin
			ctrl_use_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			channel_q <= req.channel;
			tx_id_q   <= req.transmit_id;
			ctrl_q    <= req.controller;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				scan_q <= 1'b1;
			end else if (tok_end.valid) begin
				scan_q <= 1'b0;
			end
			if (tok_end.valid) begin
				pend_valid_q <= 1'b1;
			end else if (pend_valid_q && (!rsp_valid_q || !rsp_stall)) begin
				pend_valid_q <= 1'b0;
			end
			if (pend_valid_q && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_end.valid) begin
			pend_q <= res;
		end
		if (pend_valid_q && (!rsp_valid_q || !rsp_stall)) begin
			rsp_q <= pend_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

@@ src/crt_chan_cell.sv @@
`default_nettype none
module crt_chan_cell #(
	parameter int IDX = 0
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire crt_pkg::token_t tok_in,
	input  wire crt_pkg::upd_t   upd,
	output crt_pkg::token_t      tok_out
);

	logic [crt_pkg::ID_W-1:0] rx_q;
	logic [crt_pkg::ID_W-1:0] tx_q;
	logic [1:0]               ctrl_q;
	logic                     valid_q;
	logic                     hit;
	logic                     tok_valid_q;
	crt_pkg::token_t          nxt;
	crt_pkg::token_t          tok_q;

	always_comb begin
		hit = 1'b0;
		if (tok_in.valid && !tok_in.found && valid_q) begin
			hit = (tok_in.op == crt_pkg::OP_ROUTE_RX && tok_in.ctrl_ok && rx_q == tok_in.id)
				|| (tok_in.op == crt_pkg::OP_FIND_TX && tx_q == tok_in.id);
		end
		nxt = tok_in;
		if (hit) begin
			nxt.found = 1'b1;
			nxt.kind  = crt_pkg::KIND_CHANNEL;
			nxt.idx   = crt_pkg::IDX_W'(IDX);
			nxt.tctrl = ctrl_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else begin
			tok_valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= nxt;
	end

	always_comb begin
		tok_out       = tok_q;
		tok_out.valid = tok_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (upd.clear_all) begin
			valid_q <= 1'b0;
		end else if (upd.chan_wr && upd.idx == crt_pkg::IDX_W'(IDX)) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (upd.chan_wr && upd.idx == crt_pkg::IDX_W'(IDX)) begin
			rx_q   <= upd.id;
			tx_q   <= upd.tx_id;
			ctrl_q <= upd.ctrl;
		end
	end

endmodule
`default_nettype wire

@@ src/crt_slot_cell.sv @@
`default_nettype none
module crt_slot_cell #(
	parameter int IDX = 0
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire crt_pkg::token_t tok_in,
	input  wire crt_pkg::upd_t   upd,
	output crt_pkg::token_t      tok_out
);

	logic [crt_pkg::ID_W-1:0] ident_q;
	logic                     active_q;
	logic                     hit;
	logic                     tok_valid_q;
	crt_pkg::token_t          nxt;
	crt_pkg::token_t          tok_q;

	always_comb begin
		hit = 1'b0;
		if (tok_in.valid && !tok_in.found && active_q && ident_q == tok_in.id) begin
			hit = (tok_in.op == crt_pkg::OP_ROUTE_RX && tok_in.ctrl_ok)
				|| tok_in.op == crt_pkg::OP_REGISTER
				|| tok_in.op == crt_pkg::OP_UNREGISTER;
		end
		nxt = tok_in;
		if (hit) begin
			nxt.found = 1'b1;
			nxt.kind  = crt_pkg::KIND_SLOT;
			nxt.idx   = crt_pkg::IDX_W'(IDX);
		end
		// first free slot for register
		if (tok_in.valid && !active_q && !tok_in.free_found) begin
			nxt.free_found = 1'b1;
			nxt.free_idx   = crt_pkg::IDX_W'(IDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else begin
			tok_valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= nxt;
	end

	always_comb begin
		tok_out       = tok_q;
		tok_out.valid = tok_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (upd.clear_all) begin
			active_q <= 1'b0;
		end else if (upd.idx == crt_pkg::IDX_W'(IDX)) begin
			if (upd.slot_wr) begin
				active_q <= 1'b1;
			end else if (upd.slot_free) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.slot_wr && upd.idx == crt_pkg::IDX_W'(IDX)) begin
			ident_q <= upd.id;
		end
	end

endmodule
`default_nettype wire

@@ tb/can_id_routing_table_unit_tb.sv @@
`default_nettype none
module can_id_routing_table_unit_tb;

	localparam int CHAN_N     = 16;
	localparam int SLOT_N     = 32;
	localparam int CTRL_MAX   = 4;
	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_LEN   = 700;
	localparam int HOLD_AFTER = 120;
	localparam int PHASE_LEN  = 55;
	localparam logic [2:0] OP_RESERVED_6 = 3'd6;
	localparam logic [2:0] OP_RESERVED_7 = 3'd7;
	localparam logic [crt_pkg::ID_W-1:0] ID_MAX = {crt_pkg::ID_W{1'b1}};
	localparam logic [crt_pkg::ID_W-1:0] ID_ALT_A = 29'h0AAAAAAA;
	localparam logic [crt_pkg::ID_W-1:0] ID_ALT_B = 29'h15555555;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_wdata = 3'd0;
	logic req_valid = 1'b0;
	logic req_stall;
	crt_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	crt_pkg::rsp_t rsp;

	// predictor copy of the tables
	logic [crt_pkg::ID_W-1:0] rx_tab [CHAN_N];
	logic [crt_pkg::ID_W-1:0] tx_tab [CHAN_N];
	logic [1:0] chan_ctrl_tab [CHAN_N];
	bit chan_on [CHAN_N];
	logic [crt_pkg::ID_W-1:0] slot_id_tab [SLOT_N];
	bit slot_on [SLOT_N];
	logic [2:0] ctrl_limit = 3'd1;

	crt_pkg::req_t req_backlog [$];
	crt_pkg::rsp_t rsp_due [$];
	logic [crt_pkg::ID_W-1:0] id_pool [48];

	bit req_taken = 1'b0;
	int items_taken = 0;
	int idle_cycles = 0;
	int fail_cnt = 0;
	int no_space_seen = 0;
	int op_seen [8];
	int gap_left = 0;
	int burst_left = 1;
	int stretch_left = 0;
	int stall_mode = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	can_id_routing_table_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	function automatic int chan_hit(logic [crt_pkg::ID_W-1:0] id, bit by_rx);
		for (int i = 0; i < CHAN_N; i++) begin
			if (chan_on[i] && ((by_rx ? rx_tab[i] : tx_tab[i]) == id))
				return i;
		end
		return -1;
	endfunction

	function automatic int slot_hit(logic [crt_pkg::ID_W-1:0] id);
		for (int i = 0; i < SLOT_N; i++) begin
			if (slot_on[i] && slot_id_tab[i] == id)
				return i;
		end
		return -1;
	endfunction

	function automatic crt_pkg::rsp_t route_lookup(crt_pkg::req_t r);
		crt_pkg::rsp_t o;
		int hit;
		int lim;
		bit c_ok;
		o = '0;
		o.status = crt_pkg::ST_INVALID;
		lim = (int'(ctrl_limit) > CTRL_MAX) ? CTRL_MAX : int'(ctrl_limit);
		c_ok = int'(r.controller) < lim;
		case (r.operation)
			crt_pkg::OP_ROUTE_RX: begin
				if (c_ok) begin
					o.status = crt_pkg::ST_OK;
					hit = chan_hit(r.frame_id, 1'b1);
					if (hit >= 0) begin
						o.target_kind = crt_pkg::KIND_CHANNEL;
						o.target_index = hit[4:0];
					end else begin
						hit = slot_hit(r.frame_id);
						if (hit >= 0) begin
							o.target_kind = crt_pkg::KIND_SLOT;
							o.target_index = hit[4:0];
						end
					end
				end
			end
			crt_pkg::OP_FIND_TX: begin
				hit = chan_hit(r.frame_id, 1'b0);
				if (hit >= 0) begin
					o.status = crt_pkg::ST_OK;
					o.target_kind = crt_pkg::KIND_CHANNEL;
					o.target_index = hit[4:0];
					o.target_controller = chan_ctrl_tab[hit];
				end else begin
					o.status = crt_pkg::ST_NOT_MAPPED;
				end
			end
			crt_pkg::OP_MAP: begin
				if (int'(r.channel) < CHAN_N && c_ok) begin
					rx_tab[r.channel] = r.frame_id;
					tx_tab[r.channel] = r.transmit_id;
					chan_ctrl_tab[r.channel] = r.controller;
					chan_on[r.channel] = 1'b1;
					o.status = crt_pkg::ST_OK;
					o.target_kind = crt_pkg::KIND_CHANNEL;
					o.target_index = {1'b0, r.channel};
				end
			end
			crt_pkg::OP_REGISTER: begin
				hit = slot_hit(r.frame_id);
				if (hit < 0) begin
					for (int i = 0; i < SLOT_N; i++) begin
						if (hit < 0 && !slot_on[i])
							hit = i;
					end
					if (hit >= 0) begin
						slot_id_tab[hit] = r.frame_id;
						slot_on[hit] = 1'b1;
					end
				end
				if (hit >= 0) begin
					o.status = crt_pkg::ST_OK;
					o.target_kind = crt_pkg::KIND_SLOT;
					o.target_index = hit[4:0];
				end else begin
					o.status = crt_pkg::ST_NO_SPACE;
				end
			end
			crt_pkg::OP_UNREGISTER: begin
				hit = slot_hit(r.frame_id);
				if (hit >= 0) begin
					slot_on[hit] = 1'b0;
					o.status = crt_pkg::ST_OK;
					o.target_kind = crt_pkg::KIND_SLOT;
					o.target_index = hit[4:0];
				end
			end
			crt_pkg::OP_CLEAR_ALL: begin
				for (int i = 0; i < CHAN_N; i++) begin
					rx_tab[i] = '0;
					tx_tab[i] = '0;
					chan_ctrl_tab[i] = '0;
					chan_on[i] = 1'b0;
				end
				for (int i = 0; i < SLOT_N; i++) begin
					slot_id_tab[i] = '0;
					slot_on[i] = 1'b0;
				end
				o.status = crt_pkg::ST_OK;
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic crt_pkg::req_t make_req(logic [2:0] op, logic [1:0] ctrl,
			logic [crt_pkg::ID_W-1:0] id, logic [3:0] ch, logic [crt_pkg::ID_W-1:0] tx);
		crt_pkg::req_t r;
		r.operation = op;
		r.controller = ctrl;
		r.frame_id = id;
		r.channel = ch;
		r.transmit_id = tx;
		return r;
	endfunction

	function automatic logic [crt_pkg::ID_W-1:0] pick_id(bit wide);
		if ($urandom_range(0, 9) < 8)
			return id_pool[$urandom_range(0, wide ? 47 : 11)];
		return crt_pkg::ID_W'($urandom);
	endfunction

	task automatic check_field(string name, logic [4:0] want, logic [4:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fail_cnt++;
		end
	endtask

	task automatic queue_random(int n, bit fill_slots);
		crt_pkg::req_t r;
		int pick;
		for (int k = 0; k < n; k++) begin
			r.controller = 2'($urandom_range(0, 3));
			r.channel = 4'($urandom_range(0, 15));
			r.frame_id = pick_id(fill_slots);
			r.transmit_id = pick_id(fill_slots);
			pick = $urandom_range(0, 99);
			if (fill_slots) begin
				if (pick < 70) r.operation = crt_pkg::OP_REGISTER;
				else if (pick < 80) r.operation = crt_pkg::OP_ROUTE_RX;
				else if (pick < 90) r.operation = crt_pkg::OP_UNREGISTER;
				else if (pick < 95) r.operation = crt_pkg::OP_FIND_TX;
				else r.operation = crt_pkg::OP_MAP;
			end else begin
				if (pick < 28) r.operation = crt_pkg::OP_ROUTE_RX;
				else if (pick < 43) r.operation = crt_pkg::OP_FIND_TX;
				else if (pick < 58) r.operation = crt_pkg::OP_MAP;
				else if (pick < 76) r.operation = crt_pkg::OP_REGISTER;
				else if (pick < 93) r.operation = crt_pkg::OP_UNREGISTER;
				else if (pick < 95) r.operation = crt_pkg::OP_CLEAR_ALL;
				else r.operation = $urandom_range(0, 1) ? OP_RESERVED_6 : OP_RESERVED_7;
			end
			req_backlog.push_back(r);
		end
	endtask

	task automatic wait_drained();
		while (req_backlog.size() != 0 || req_valid || rsp_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_ctrl_limit(logic [2:0] v);
		wait_drained();
		repeat (2) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (req_valid && !req_taken) begin
		end else if (gap_left > 0) begin
			req_valid <= 1'b0;
			gap_left = gap_left - 1;
		end else if (req_backlog.size() != 0) begin
			req <= req_backlog.pop_front();
			req_valid <= 1'b1;
			if (burst_left <= 1) begin
				burst_left = $urandom_range(1, 12);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
			end else begin
				burst_left = burst_left - 1;
			end
		end else begin
			req_valid <= 1'b0;
		end
	end

	// response stall pattern, with one long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else if (!hold_done && items_taken >= HOLD_AFTER) begin
			hold_done = 1'b1;
			hold_left = HOLD_LEN;
			rsp_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left = hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			if (stretch_left == 0) begin
				stretch_left = $urandom_range(10, 150);
				stall_mode = $urandom_range(0, 2);
			end else begin
				stretch_left = stretch_left - 1;
			end
			case (stall_mode)
				0: rsp_stall <= 1'b0;
				1: rsp_stall <= 1'($urandom_range(0, 1));
				default: rsp_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		crt_pkg::rsp_t want;
		req_taken = 1'b0;
		if (arst_n) begin
			if (cfg_we)
				ctrl_limit = cfg_wdata;
			idle_cycles++;
			if (rsp_valid && !rsp_stall) begin
				idle_cycles = 0;
				if (rsp_due.size() == 0) begin
					$display("%0t: unexpected item, expected none, actual %h", $time, rsp);
					fail_cnt++;
				end else begin
					want = rsp_due.pop_front();
					check_field("status", want.status, rsp.status);
					check_field("target_kind", want.target_kind, rsp.target_kind);
					check_field("target_index", want.target_index, rsp.target_index);
					check_field("target_controller", want.target_controller,
						rsp.target_controller);
					if (want.status == crt_pkg::ST_NO_SPACE)
						no_space_seen++;
				end
			end
			if (req_valid && !req_stall) begin
				idle_cycles = 0;
				req_taken = 1'b1;
				items_taken++;
				op_seen[req.operation]++;
				rsp_due.push_back(route_lookup(req));
			end
		end
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(negedge clk);
		$display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		logic [2:0] settings [8];
		settings = '{3'd0, 3'd4, 3'd7, 3'd2, 3'd3, 3'd6, 3'd5, 3'd1};
		id_pool[0] = '0;
		id_pool[1] = ID_MAX;
		id_pool[2] = ID_ALT_A;
		id_pool[3] = ID_ALT_B;
		for (int i = 4; i < 48; i++)
			id_pool[i] = crt_pkg::ID_W'($urandom);
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// directed part at the reset setting of one controller
		req_backlog.push_back(make_req(crt_pkg::OP_ROUTE_RX, 2'd0, '0, 4'd0, '0));
		req_backlog.push_back(make_req(crt_pkg::OP_FIND_TX, 2'd0, '0, 4'd0, '0));
		req_backlog.push_back(make_req(crt_pkg::OP_MAP, 2'd0, '0, 4'd0, ID_MAX));
		req_backlog.push_back(make_req(crt_pkg::OP_MAP, 2'd1, ID_MAX, 4'd15, '0));
		req_backlog.push_back(make_req(crt_pkg::OP_MAP, 2'd0, ID_MAX, 4'd15, '0));
		req_backlog.push_back(make_req(crt_pkg::OP_ROUTE_RX, 2'd0, ID_MAX, 4'd0, '0));
		req_backlog.push_back(make_req(crt_pkg::OP_ROUTE_RX, 2'd3, ID_MAX, 4'd15, ID_MAX));
		req_backlog.push_back(make_req(crt_pkg::OP_FIND_TX, 2'd0, ID_MAX, 4'd0, '0));
		req_backlog.push_back(make_req(crt_pkg::OP_REGISTER, 2'd0, ID_MAX, 4'd0, '0));
		req_backlog.push_back(make_req(crt_pkg::OP_REGISTER, 2'd0, ID_ALT_A, 4'd0, '0));
		req_backlog.push_back(make_req(crt_pkg::OP_REGISTER, 2'd0, ID_MAX, 4'd0, '0));
		req_backlog.push_back(make_req(crt_pkg::OP_ROUTE_RX, 2'd0, ID_MAX, 4'd0, '0));
		req_backlog.push_back(make_req(crt_pkg::OP_ROUTE_RX, 2'd0, ID_ALT_A, 4'd0, '0));
		req_backlog.push_back(make_req(crt_pkg::OP_UNREGISTER, 2'd0, ID_ALT_B, 4'd0, '0));
		req_backlog.push_back(make_req(crt_pkg::OP_UNREGISTER, 2'd0, ID_MAX, 4'd0, '0));
		req_backlog.push_back(make_req(crt_pkg::OP_REGISTER, 2'd0, ID_ALT_B, 4'd0, '0));
		req_backlog.push_back(make_req(crt_pkg::OP_MAP, 2'd0, ID_ALT_A, 4'd0, ID_ALT_B));
		req_backlog.push_back(make_req(crt_pkg::OP_ROUTE_RX, 2'd0, ID_ALT_A, 4'd0, '0));
		req_backlog.push_back(make_req(crt_pkg::OP_FIND_TX, 2'd0, ID_ALT_B, 4'd0, '0));
		req_backlog.push_back(make_req(OP_RESERVED_6, 2'd3, ID_MAX, 4'd15, ID_MAX));
		req_backlog.push_back(make_req(OP_RESERVED_7, 2'd3, ID_MAX, 4'd15, ID_MAX));
		req_backlog.push_back(make_req(crt_pkg::OP_CLEAR_ALL, 2'd3, ID_MAX, 4'd15, ID_MAX));
		req_backlog.push_back(make_req(crt_pkg::OP_ROUTE_RX, 2'd0, ID_ALT_A, 4'd0, '0));
		req_backlog.push_back(make_req(crt_pkg::OP_FIND_TX, 2'd0, ID_ALT_B, 4'd0, '0));

		// random phases, one per controller setting
		foreach (settings[p]) begin
			set_ctrl_limit(settings[p]);
			queue_random(PHASE_LEN, p == 4);
		end

		wait_drained();
		repeat (60) @(posedge clk);
		if (rsp_due.size() != 0) begin
			$display("%0t: %0d items still expected", $time, rsp_due.size());
			fail_cnt++;
		end
		$display("run: %0d items (route %0d, find_tx %0d, map %0d, register %0d, unregister %0d,",
			items_taken, op_seen[crt_pkg::OP_ROUTE_RX], op_seen[crt_pkg::OP_FIND_TX],
			op_seen[crt_pkg::OP_MAP], op_seen[crt_pkg::OP_REGISTER],
			op_seen[crt_pkg::OP_UNREGISTER]);
		$display("  clear %0d, reserved %0d), %0d full-table rejects, controller limits 0..7",
			op_seen[crt_pkg::OP_CLEAR_ALL], op_seen[OP_RESERVED_6] + op_seen[OP_RESERVED_7],
			no_space_seen);
		if (fail_cnt == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire
